// File: rtl/oled_update_run_coalescer_top_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef OLED_UPDATE_RUN_COALESCER_TOP_MACROS_SVH
`define OLED_UPDATE_RUN_COALESCER_TOP_MACROS_SVH

// same-cycle implication
`define OURC_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oled coalescer check failed");

// next-cycle implication
`define OURC_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oled coalescer check failed");

`endif

// File: rtl/oled_urc_pkg.sv
package oled_urc_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [0:0]  REG_BUS_ADDRESS = 1'b0;
    localparam logic [6:0]  BUS_ADDR_RESET = 7'd60;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_BYTE  = 2'd1,
        EV_STOP  = 2'd2
    } bus_event_t;

    localparam logic [7:0] CMD_CTRL       = 8'h00;
    localparam logic [7:0] DATA_CTRL      = 8'h40;
    localparam logic [7:0] PAGE_CMD       = 8'hB0;
    localparam logic [7:0] COL_HI_CMD     = 8'h10;
    localparam logic [3:0] MAX_PAGE       = 4'd7;
    localparam logic [7:0] MAX_COL        = 8'd127;
    localparam logic [7:0] RAM_COL_OFFSET = 8'd2;

    // event slots of one item, in output order
    localparam int unsigned NUM_STEPS  = 11;
    localparam int unsigned STEP_IDX_W = $clog2(NUM_STEPS);

    typedef logic [STEP_IDX_W-1:0] step_idx_t;
    typedef logic [NUM_STEPS-1:0]  step_mask_t;

    localparam step_idx_t STEP_CLOSE     = step_idx_t'(0);
    localparam step_idx_t STEP_CUR_START = step_idx_t'(1);
    localparam step_idx_t STEP_CTRL      = step_idx_t'(2);
    localparam step_idx_t STEP_PAGE      = step_idx_t'(3);
    localparam step_idx_t STEP_COL_LO    = step_idx_t'(4);
    localparam step_idx_t STEP_COL_HI    = step_idx_t'(5);
    localparam step_idx_t STEP_CUR_STOP  = step_idx_t'(6);
    localparam step_idx_t STEP_DAT_START = step_idx_t'(7);
    localparam step_idx_t STEP_DAT_CTRL  = step_idx_t'(8);
    localparam step_idx_t STEP_PIXEL     = step_idx_t'(9);
    localparam step_idx_t STEP_LAST_STOP = step_idx_t'(10);

    typedef struct packed {
        step_mask_t  mask;
        logic [2:0]  page;
        logic [7:0]  col_ram;
        logic [7:0]  pixel;
    } desc_t;

    function automatic bus_event_t step_event(input step_idx_t idx);
        bus_event_t ev;
        case (idx)
            STEP_CUR_START, STEP_DAT_START:            ev = EV_START;
            STEP_CLOSE, STEP_CUR_STOP, STEP_LAST_STOP: ev = EV_STOP;
            default:                                   ev = EV_BYTE;
        endcase
        return ev;
    endfunction

    function automatic logic [7:0] step_byte(input step_idx_t idx, input desc_t d,
                                             input logic [6:0] addr);
        logic [7:0] b;
        case (idx)
            STEP_CUR_START, STEP_DAT_START: b = {1'b0, addr};
            STEP_CTRL:                      b = CMD_CTRL;
            STEP_PAGE:                      b = PAGE_CMD | {5'b0, d.page};
            STEP_COL_LO:                    b = {4'b0, d.col_ram[3:0]};
            STEP_COL_HI:                    b = COL_HI_CMD | {4'b0, d.col_ram[7:4]};
            STEP_DAT_CTRL:                  b = DATA_CTRL;
            STEP_PIXEL:                     b = d.pixel;
            default:                        b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/oled_urc_if.sv
interface oled_urc_upd_if;
    logic       valid;
    logic       ready;
    logic [3:0] page_index;
    logic [7:0] column_index;
    logic [7:0] pixel_byte;
    logic       last_in_batch;

    modport source (output valid, page_index, column_index, pixel_byte, last_in_batch,
                    input ready);
    modport sink   (input valid, page_index, column_index, pixel_byte, last_in_batch,
                    output ready);
endinterface

interface oled_urc_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] bus_event;
    logic [7:0] bus_byte;
    logic       last_of_run;

    modport source (output valid, bus_event, bus_byte, last_of_run, input ready);
    modport sink   (input valid, bus_event, bus_byte, last_of_run, output ready);
endinterface

// File: rtl/oled_urc_front.sv
`include "oled_update_run_coalescer_top_macros.svh"

module oled_urc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    oled_urc_upd_if.sink         upd,
    input  logic                 full,
    output logic                 push,
    output oled_urc_pkg::desc_t  push_desc
);

    logic       run_open_reg, run_open_next;
    logic [3:0] run_page_reg, run_page_next;
    logic [7:0] exp_col_reg, exp_col_next;
    logic       cont;
    logic       cursor;

    assign upd.ready = !full;
    assign push      = upd.valid && !full;

    // continuing byte of the open data write
    assign cont   = run_open_reg && (upd.page_index == run_page_reg)
                    && (upd.column_index == exp_col_reg);
    assign cursor = !cont && (upd.page_index <= oled_urc_pkg::MAX_PAGE)
                    && (upd.column_index <= oled_urc_pkg::MAX_COL);

    always_comb
    begin
        push_desc         = '0;
        push_desc.page    = upd.page_index[2:0];
        push_desc.col_ram = upd.column_index + oled_urc_pkg::RAM_COL_OFFSET;
        push_desc.pixel   = upd.pixel_byte;
        push_desc.mask[oled_urc_pkg::STEP_CLOSE]     = run_open_reg && !cont;
        push_desc.mask[oled_urc_pkg::STEP_CUR_START] = cursor;
        push_desc.mask[oled_urc_pkg::STEP_CTRL]      = cursor;
        push_desc.mask[oled_urc_pkg::STEP_PAGE]      = cursor;
        push_desc.mask[oled_urc_pkg::STEP_COL_LO]    = cursor;
        push_desc.mask[oled_urc_pkg::STEP_COL_HI]    = cursor;
        push_desc.mask[oled_urc_pkg::STEP_CUR_STOP]  = cursor;
        push_desc.mask[oled_urc_pkg::STEP_DAT_START] = !cont;
        push_desc.mask[oled_urc_pkg::STEP_DAT_CTRL]  = !cont;
        push_desc.mask[oled_urc_pkg::STEP_PIXEL]     = 1'b1;
        push_desc.mask[oled_urc_pkg::STEP_LAST_STOP] = upd.last_in_batch;
    end

    always_comb
    begin
        run_open_next = run_open_reg;
        run_page_next = run_page_reg;
        exp_col_next  = exp_col_reg;
        if (push)
        begin
            exp_col_next = upd.column_index + 8'd1;
            if (!cont)
            begin
                run_open_next = 1'b1;
                run_page_next = upd.page_index;
            end
            if (upd.last_in_batch)
            begin
                run_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            run_page_reg <= '0;
            exp_col_reg  <= '0;
        end
        else
        begin
            run_open_reg <= run_open_next;
            run_page_reg <= run_page_next;
            exp_col_reg  <= exp_col_next;
        end
    end

    `OURC_CHECK_NEXT(a_batch_end_closes, push && upd.last_in_batch, !run_open_reg)
    `OURC_CHECK(a_cont_needs_open_run, push && cont, run_open_reg)

endmodule

// File: rtl/oled_urc_fifo.sv
`include "oled_update_run_coalescer_top_macros.svh"

module oled_urc_fifo #(
    parameter int unsigned DEPTH = oled_urc_pkg::FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  oled_urc_pkg::desc_t  push_data,
    input  logic                 pop,
    output oled_urc_pkg::desc_t  pop_data,
    output logic                 empty,
    output logic                 full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    oled_urc_pkg::desc_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `OURC_CHECK(a_no_overflow, push, !full)
    `OURC_CHECK(a_no_underflow, pop, !empty)

endmodule

// File: rtl/oled_urc_back.sv
`include "oled_update_run_coalescer_top_macros.svh"

module oled_urc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [6:0]           bus_address,
    input  logic                 empty,
    input  oled_urc_pkg::desc_t  head,
    output logic                 pop,
    oled_urc_evt_if.source       evt
);

    logic                     cur_valid_reg, cur_valid_next;
    oled_urc_pkg::desc_t      cur_reg, cur_next;
    logic                     out_valid_reg, out_valid_next;
    oled_urc_pkg::bus_event_t out_event_reg, out_event_next;
    logic [7:0]               out_byte_reg, out_byte_next;
    logic                     out_last_reg, out_last_next;

    logic                     load_ok;
    logic                     emit;
    logic                     done;
    oled_urc_pkg::step_mask_t low;
    oled_urc_pkg::step_mask_t rest;
    oled_urc_pkg::step_idx_t  idx;

    assign evt.valid       = out_valid_reg;
    assign evt.bus_event   = out_event_reg;
    assign evt.bus_byte    = out_byte_reg;
    assign evt.last_of_run = out_last_reg;

    assign load_ok = !out_valid_reg || evt.ready;
    assign low     = cur_reg.mask & (~cur_reg.mask + 1'b1);
    assign rest    = cur_reg.mask & ~low;
    assign emit    = cur_valid_reg && load_ok;
    assign done    = emit && (rest == '0);
    assign pop     = !empty && (!cur_valid_reg || done);

    // lowest pending slot to index
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < oled_urc_pkg::NUM_STEPS; i++)
        begin
            if (low[i])
            begin
                idx = oled_urc_pkg::step_idx_t'(i);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_event_next = oled_urc_pkg::step_event(idx);
            out_byte_next  = oled_urc_pkg::step_byte(idx, cur_reg, bus_address);
            out_last_next  = (rest == '0);
            cur_next.mask  = rest;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = head;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_event_reg <= out_event_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OURC_CHECK(a_cur_has_work, cur_valid_reg, cur_reg.mask != '0)
    `OURC_CHECK_NEXT(a_done_marks_last, done, out_valid_reg && out_last_reg)

endmodule

// File: rtl/oled_update_run_coalescer_top.sv
// an accepted item goes via the queue and current-item register to the output register
// throughput: one event per cycle from the output register, held by evt.ready, not intake
// a continuing byte costs 1 event (2 at end of batch), a run break up to 11 events
// intake runs ahead through a small queue of classified items until the queue fills
// reset: asynchronous, clears run state, queue and output valid; bus_address returns to 60
module oled_update_run_coalescer_top #(
    parameter int unsigned FIFO_DEPTH = oled_urc_pkg::FIFO_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [oled_urc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [oled_urc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [oled_urc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    oled_urc_upd_if.sink                        upd,
    oled_urc_evt_if.source                      evt
);

    logic [6:0]          bus_address_reg, bus_address_next;
    logic                reg_sel;
    logic                push;
    logic                pop;
    logic                empty;
    logic                full;
    oled_urc_pkg::desc_t push_desc;
    oled_urc_pkg::desc_t head;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[oled_urc_pkg::APB_ADDR_W-1:2] == oled_urc_pkg::REG_BUS_ADDRESS);
    assign prdata  = reg_sel ? {{(oled_urc_pkg::APB_DATA_W - 7){1'b0}}, bus_address_reg}
                             : '0;

    always_comb
    begin
        bus_address_next = bus_address_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            bus_address_next = pwdata[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_address_reg <= oled_urc_pkg::BUS_ADDR_RESET;
        end
        else
        begin
            bus_address_reg <= bus_address_next;
        end
    end

    oled_urc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .full      (full),
        .push      (push),
        .push_desc (push_desc)
    );

    oled_urc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty),
        .full      (full)
    );

    oled_urc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .bus_address (bus_address_reg),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .evt         (evt)
    );

endmodule
